[design/bbmt_pkg.sv]
// Shared constants and hash helpers for the blocked Bloom membership test core.
// Depends on nothing; the top level and the table RAM take names from here.
package bbmt_pkg;

    localparam int unsigned BLOCK_COUNT_DEFAULT = 2048;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned LIDX_W    = 11;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BIT_SEL_W = 5;
    localparam int unsigned H1_W      = 16;

    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [31:0] SEED_XOR   = 32'hDEADBEEF;
    localparam logic [31:0] GOLDEN_MUL = 32'd2654435761;
    localparam logic [31:0] MIX_MUL    = 32'h045D9F3B;

    localparam logic ACTION_QUERY = 1'b0;
    localparam logic ACTION_LOAD  = 1'b1;

    // Three-step xorshift: 13 right, 17 left, 5 right.
    function automatic logic [31:0] xorshift32(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v >> 13);
        t = t ^ (t << 17);
        t = t ^ (t >> 5);
        return t;
    endfunction

    // Fold the upper half of a word onto the lower half.
    function automatic logic [31:0] fold16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

endpackage

[design/bbmt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on bbmt_pkg for its default width and depth.
module bbmt_ram #(
    parameter int unsigned WIDTH = bbmt_pkg::WORD_W,
    parameter int unsigned DEPTH = bbmt_pkg::BLOCK_COUNT_DEFAULT,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/blocked_bloom_membership_test_core.sv]
// Blocked Bloom filter membership test core; depends on bbmt_pkg and bbmt_ram.
// A query passes stages A, B, C, D and E, and its result is then held in the output register.
// Throughput: one request per cycle unless m_axis_tready holds a full output register.
// Loads write the table in the same pipeline stage as queries read it, so order holds.
// Reset (aresetn, synchronous, active low) clears all valid flags; the table is
// not cleared and holds nothing defined until it has been loaded.
module blocked_bloom_membership_test_core #(
    parameter int unsigned BLOCK_COUNT = bbmt_pkg::BLOCK_COUNT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [20:0] scalar_value, [31:21] load_index, [63:32] load_word
    input  logic [bbmt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] action (0 query, 1 load)
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] relevant, [7:1] zero
    output logic [bbmt_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // Table index width, and the reciprocal used to reduce the 16-bit block hash
    // modulo BLOCK_COUNT without a divider. RECIP = floor(2^32 / BLOCK_COUNT) makes
    // the estimated quotient at most one short, so one compare and subtract fixes it.
    localparam int unsigned IDX_W   = $clog2(BLOCK_COUNT);
    localparam int unsigned RECIP_W = 33 - IDX_W;
    localparam int unsigned QP_W    = bbmt_pkg::H1_W + RECIP_W;
    localparam int unsigned Q_W     = QP_W - 32;
    localparam int unsigned LWIDE_W = bbmt_pkg::LIDX_W + IDX_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / BLOCK_COUNT);
    localparam logic [IDX_W:0]     BC_R  = (IDX_W + 1)'(BLOCK_COUNT);
    localparam logic [16:0]        BC_17 = 17'(BLOCK_COUNT);

    // The whole pipe moves together whenever the output register is free or is
    // being emptied in this cycle. The input ready follows the output side within
    // the same cycle.
    logic pipe_advance;
    logic m_valid_reg;
    logic m_relevant_reg;

    assign pipe_advance  = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_advance;

    // Stage A: the accepted request, unpacked.
    logic                          a_valid_reg;
    logic                          a_action_reg;
    logic [bbmt_pkg::CP_W-1:0]     a_cp_reg;
    logic [bbmt_pkg::LIDX_W-1:0]   a_lidx_reg;
    logic [bbmt_pkg::WORD_W-1:0]   a_lword_reg;

    // Stage B: block hash, first mixing round, low bits of the xorshift hash.
    logic                          b_valid_reg;
    logic                          b_action_reg;
    logic [bbmt_pkg::LIDX_W-1:0]   b_lidx_reg;
    logic [bbmt_pkg::WORD_W-1:0]   b_lword_reg;
    logic [bbmt_pkg::H1_W-1:0]     b_h1_reg;
    logic [31:0]                   b_m1_reg;
    logic [bbmt_pkg::BIT_SEL_W-1:0] b_h2_reg;

    // Stage C: quotient estimate and second mixing round.
    logic                          c_valid_reg;
    logic                          c_action_reg;
    logic [bbmt_pkg::LIDX_W-1:0]   c_lidx_reg;
    logic [bbmt_pkg::WORD_W-1:0]   c_lword_reg;
    logic [bbmt_pkg::H1_W-1:0]     c_h1_reg;
    logic [Q_W-1:0]                c_q_reg;
    logic [bbmt_pkg::BIT_SEL_W-1:0] c_h2_reg;
    logic [31:0]                   c_m2_reg;

    // Stage D: partial remainder and the 32-bit select mask with up to three bits set. The table is
    // read or written from this stage.
    logic                          d_valid_reg;
    logic                          d_action_reg;
    logic [bbmt_pkg::LIDX_W-1:0]   d_lidx_reg;
    logic [bbmt_pkg::WORD_W-1:0]   d_lword_reg;
    logic [IDX_W:0]                d_rem_reg;
    logic [31:0]                   d_sel_reg;

    // Stage E: a query waiting on the table word in the RAM read register.
    logic                          e_query_reg;
    logic [31:0]                   e_sel_reg;

    // Hash datapath between stages.
    logic [31:0]          a_cp_ext;
    logic [31:0]          a_h1_prod;
    logic [31:0]          a_m1;
    logic [31:0]          a_h2;
    logic [QP_W-1:0]      b_q_prod;
    logic [31:0]          b_m2;
    logic [31:0]          c_h3;
    logic [bbmt_pkg::BIT_SEL_W-1:0] c_h3_lo;
    logic [bbmt_pkg::BIT_SEL_W-1:0] c_hd_lo;
    logic [31:0]          c_sel;
    logic [16:0]          c_qbc;
    logic [16:0]          c_rem0;

    assign a_cp_ext  = 32'(a_cp_reg);
    assign a_h1_prod = (a_cp_ext ^ bbmt_pkg::SEED_XOR) * bbmt_pkg::GOLDEN_MUL;
    assign a_m1      = bbmt_pkg::fold16(a_cp_ext) * bbmt_pkg::MIX_MUL;
    assign a_h2      = bbmt_pkg::xorshift32(a_cp_ext);

    assign b_q_prod  = QP_W'(b_h1_reg) * QP_W'(RECIP);
    assign b_m2      = bbmt_pkg::fold16(b_m1_reg) * bbmt_pkg::MIX_MUL;

    // Only the low five bits of h2 + 3*h3 choose a bit, and those depend only on
    // the low five bits of each operand.
    assign c_h3    = bbmt_pkg::fold16(c_m2_reg);
    assign c_h3_lo = c_h3[bbmt_pkg::BIT_SEL_W-1:0];
    assign c_hd_lo = c_h2_reg + (c_h3_lo << 1) + c_h3_lo;
    assign c_sel   = (32'd1 << c_h2_reg) | (32'd1 << c_h3_lo) | (32'd1 << c_hd_lo);
    assign c_qbc   = 17'(c_q_reg * BLOCK_COUNT);
    assign c_rem0  = 17'(c_h1_reg) - c_qbc;

    // Table access from stage D.
    logic                          d_lidx_ok;
    logic [LWIDE_W-1:0]            d_lidx_wide;
    logic [IDX_W-1:0]              d_wr_addr;
    logic [IDX_W:0]                d_rem_fix;
    logic [IDX_W-1:0]              d_rd_addr;
    logic                          tbl_wr_en;
    logic [bbmt_pkg::WORD_W-1:0]   tbl_rd_data;

    assign d_lidx_ok   = 17'(d_lidx_reg) < BC_17;
    assign d_lidx_wide = {{IDX_W{1'b0}}, d_lidx_reg};
    assign d_wr_addr   = d_lidx_wide[IDX_W-1:0];
    assign d_rem_fix   = (d_rem_reg >= BC_R) ? (d_rem_reg - BC_R) : d_rem_reg;
    assign d_rd_addr   = d_rem_fix[IDX_W-1:0];

    // A load past the end of the table is dropped.
    assign tbl_wr_en = pipe_advance && d_valid_reg
                       && (d_action_reg == bbmt_pkg::ACTION_LOAD) && d_lidx_ok;

    bbmt_ram #(
        .WIDTH (bbmt_pkg::WORD_W),
        .DEPTH (BLOCK_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (d_wr_addr),
        .wr_data (d_lword_reg),
        .rd_en   (pipe_advance),
        .rd_addr (d_rd_addr),
        .rd_data (tbl_rd_data)
    );

    // Valid flags and the output flag carry reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_query_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_advance) begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_query_reg <= d_valid_reg && (d_action_reg == bbmt_pkg::ACTION_QUERY);
            m_valid_reg <= e_query_reg;
        end
    end

    // Payload registers need no reset; they move only with the pipe.
    always_ff @(posedge aclk) begin
        if (pipe_advance) begin
            a_action_reg <= s_axis_tuser;
            a_cp_reg     <= s_axis_tdata[20:0];
            a_lidx_reg   <= s_axis_tdata[31:21];
            a_lword_reg  <= s_axis_tdata[63:32];

            b_action_reg <= a_action_reg;
            b_lidx_reg   <= a_lidx_reg;
            b_lword_reg  <= a_lword_reg;
            b_h1_reg     <= a_h1_prod[31:16];
            b_m1_reg     <= a_m1;
            b_h2_reg     <= a_h2[bbmt_pkg::BIT_SEL_W-1:0];

            c_action_reg <= b_action_reg;
            c_lidx_reg   <= b_lidx_reg;
            c_lword_reg  <= b_lword_reg;
            c_h1_reg     <= b_h1_reg;
            c_q_reg      <= b_q_prod[QP_W-1:32];
            c_h2_reg     <= b_h2_reg;
            c_m2_reg     <= b_m2;

            d_action_reg <= c_action_reg;
            d_lidx_reg   <= c_lidx_reg;
            d_lword_reg  <= c_lword_reg;
            d_rem_reg    <= c_rem0[IDX_W:0];
            d_sel_reg    <= c_sel;

            e_sel_reg    <= d_sel_reg;

            // Relevant when every selected bit of the block is set.
            m_relevant_reg <= (tbl_rd_data & e_sel_reg) == e_sel_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(bbmt_pkg::M_TDATA_W - 1){1'b0}}, m_relevant_reg};

endmodule
